// ===== src/slrep_pkg.sv =====
package slrep_pkg;

  // Token classes, one per column of the action table.
  typedef enum logic [2:0] {
    TK_ID    = 3'd0,
    TK_PLUS  = 3'd1,
    TK_STAR  = 3'd2,
    TK_LPAR  = 3'd3,
    TK_RPAR  = 3'd4,
    TK_END   = 3'd5,
    TK_BAD   = 3'd6
  } tok_t;

  // Kind of parser action.
  typedef enum logic [1:0] {
    AK_ERR    = 2'd0,
    AK_SHIFT  = 2'd1,
    AK_REDUCE = 2'd2,
    AK_ACCEPT = 2'd3
  } act_kind_t;

  typedef struct packed {
    act_kind_t  kind;
    logic [3:0] arg;
  } act_t;

  // Result of a goto lookup; ok is low where the table has no entry.
  typedef struct packed {
    logic       ok;
    logic [3:0] state;
  } goto_t;

  // Nonterminals on the left-hand side of a rule.
  typedef enum logic [1:0] {
    NT_E = 2'd0,
    NT_T = 2'd1,
    NT_F = 2'd2
  } nterm_t;

  // Rule numbers: E+T, E->T, T*F, T->F, (E), id.
  localparam logic [2:0] RULE_ADD   = 3'd1;
  localparam logic [2:0] RULE_E_T   = 3'd2;
  localparam logic [2:0] RULE_MUL   = 3'd3;
  localparam logic [2:0] RULE_T_F   = 3'd4;
  localparam logic [2:0] RULE_PAREN = 3'd5;
  localparam logic [2:0] RULE_ID    = 3'd6;

  // Status codes of a status record.
  typedef enum logic [2:0] {
    STS_SHIFTED  = 3'd0,
    STS_ACCEPTED = 3'd1,
    STS_SYNTAX   = 3'd2,
    STS_STACK    = 3'd3,
    STS_TEMP     = 3'd4
  } status_t;

  localparam logic REC_CODE   = 1'b0;
  localparam logic REC_STATUS = 1'b1;
  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_MUL     = 1'b1;

  // Reduction passes allowed per token before it counts as a syntax error.
  localparam int unsigned MAX_STEPS = 16;

  // Sequencer states.
  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_DECIDE = 2'd1,
    FSM_REDUCE = 2'd2,
    FSM_FAIL   = 2'd3
  } fsm_t;

  // Stack port strobes.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } stk_ctl_t;

  // One result record.
  typedef struct packed {
    logic       record_kind;
    logic [7:0] dest_temp;
    logic       operator_kind;
    logic       left_is_temp;
    logic [7:0] left_value;
    logic       right_is_temp;
    logic [7:0] right_value;
    logic [2:0] status_code;
    logic       last_record;
  } rec_t;

  function automatic tok_t classify(input logic [7:0] c);
    tok_t t;
    if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
        (c >= 8'h61 && c <= 8'h7A)) begin
      t = TK_ID;
    end else begin
      unique case (c)
        8'h2B:   t = TK_PLUS;
        8'h2A:   t = TK_STAR;
        8'h28:   t = TK_LPAR;
        8'h29:   t = TK_RPAR;
        8'h24:   t = TK_END;
        default: t = TK_BAD;
      endcase
    end
    return t;
  endfunction

  function automatic act_t mk(input act_kind_t k, input logic [3:0] a);
    act_t r;
    r.kind = k;
    r.arg  = a;
    return r;
  endfunction

  // SLR(1) action table.
  function automatic act_t action_of(input logic [3:0] st, input tok_t t);
    act_t r;
    r = mk(AK_ERR, 4'd0);
    unique case (st)
      4'd0, 4'd4, 4'd6, 4'd7: begin
        if (t == TK_ID) r = mk(AK_SHIFT, 4'd5);
        else if (t == TK_LPAR) r = mk(AK_SHIFT, 4'd4);
      end
      4'd1: begin
        if (t == TK_PLUS) r = mk(AK_SHIFT, 4'd6);
        else if (t == TK_END) r = mk(AK_ACCEPT, 4'd0);
      end
      4'd2, 4'd9: begin
        if (t == TK_STAR) r = mk(AK_SHIFT, 4'd7);
        else if (t == TK_PLUS || t == TK_RPAR || t == TK_END)
          r = mk(AK_REDUCE, (st == 4'd2) ? 4'(RULE_E_T) : 4'(RULE_ADD));
      end
      4'd3, 4'd5, 4'd10, 4'd11: begin
        if (t == TK_PLUS || t == TK_STAR || t == TK_RPAR || t == TK_END) begin
          unique case (st)
            4'd3:    r = mk(AK_REDUCE, 4'(RULE_T_F));
            4'd5:    r = mk(AK_REDUCE, 4'(RULE_ID));
            4'd10:   r = mk(AK_REDUCE, 4'(RULE_MUL));
            default: r = mk(AK_REDUCE, 4'(RULE_PAREN));
          endcase
        end
      end
      4'd8: begin
        if (t == TK_PLUS) r = mk(AK_SHIFT, 4'd6);
        else if (t == TK_RPAR) r = mk(AK_SHIFT, 4'd11);
      end
      default: r = mk(AK_ERR, 4'd0);
    endcase
    return r;
  endfunction

  // Goto table on nonterminals.
  function automatic goto_t goto_of(input logic [3:0] st, input nterm_t nt);
    goto_t g;
    g = '0;
    unique case (st)
      4'd0: begin
        g.ok = 1'b1;
        g.state = (nt == NT_E) ? 4'd1 : (nt == NT_T) ? 4'd2 : 4'd3;
      end
      4'd4: begin
        g.ok = 1'b1;
        g.state = (nt == NT_E) ? 4'd8 : (nt == NT_T) ? 4'd2 : 4'd3;
      end
      4'd6: begin
        g.ok = (nt != NT_E);
        g.state = (nt == NT_T) ? 4'd9 : 4'd3;
      end
      4'd7: begin
        g.ok = (nt == NT_F);
        g.state = 4'd10;
      end
      default: g = '0;
    endcase
    return g;
  endfunction

  function automatic logic [1:0] rule_len(input logic [2:0] rule);
    return (rule == RULE_ADD || rule == RULE_MUL || rule == RULE_PAREN) ? 2'd3 : 2'd1;
  endfunction

  function automatic nterm_t rule_lhs(input logic [2:0] rule);
    nterm_t n;
    unique case (rule)
      RULE_ADD, RULE_E_T: n = NT_E;
      RULE_MUL, RULE_T_F: n = NT_T;
      default:            n = NT_F;
    endcase
    return n;
  endfunction

endpackage

// ===== src/slrep_stack.sv =====
module slrep_stack
  import slrep_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned AW          = $clog2(STACK_DEPTH)
) (
  input  logic          clk,
  input  stk_ctl_t      ctl,
  input  logic [AW-1:0] wr_addr,
  input  logic [3:0]    wr_state,
  input  logic [8:0]    wr_opnd,
  input  logic [AW-1:0] rd_state_addr,
  input  logic [AW-1:0] rd_opnd_addr,
  output logic [3:0]    rd_state,
  output logic [8:0]    rd_opnd
);

  logic [3:0] state_mem [STACK_DEPTH];
  logic [8:0] opnd_mem  [STACK_DEPTH];

  // Both stacks share the write address; each has its own read address.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      state_mem[wr_addr] <= wr_state;
      opnd_mem[wr_addr]  <= wr_opnd;
    end
  end

  // Registered read data.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_state <= state_mem[rd_state_addr];
      rd_opnd  <= opnd_mem[rd_opnd_addr];
    end
  end

endmodule

// ===== src/slrep_ctrl.sv =====
module slrep_ctrl
  import slrep_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned AW          = $clog2(STACK_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  output logic          out_valid,
  input  logic          out_ready,
  output rec_t          out_rec,
  output stk_ctl_t      stk_ctl,
  output logic [AW-1:0] wr_addr,
  output logic [3:0]    wr_state,
  output logic [8:0]    wr_opnd,
  output logic [AW-1:0] rd_state_addr,
  output logic [AW-1:0] rd_opnd_addr,
  input  logic [3:0]    rd_state,
  input  logic [8:0]    rd_opnd
);

  localparam logic [AW:0] DEPTH_EXT = (AW+1)'(STACK_DEPTH);

  fsm_t          fsm, fsm_next;
  tok_t          tok, tok_next;
  logic [7:0]    tok_byte, tok_byte_next;
  logic [AW-1:0] top, top_next;
  logic [3:0]    top_state, top_state_next;
  logic [8:0]    top_opnd, top_opnd_next;
  logic [8:0]    next_temp, next_temp_next;
  logic [4:0]    iter, iter_next;
  logic [1:0]    nrec, nrec_next;
  logic [2:0]    rule, rule_next;
  rec_t          rec, rec_next;
  logic          rec_valid, rec_valid_next;

  // Shared decision signals.
  logic          out_busy;
  act_t          act;
  logic [2:0]    act_rule;
  logic          act_arith;
  logic          steps_done;
  logic          push_full;
  logic          red_bad;
  logic          tmp_ovf;
  logic          rec_full;
  logic          red_go;
  logic          rule_arith;
  logic [AW-1:0] base;
  logic [3:0]    base_state;
  goto_t         gto;
  logic          restart;

  always_comb begin
    out_busy   = rec_valid && !out_ready;
    act        = action_of(top_state, tok);
    act_rule   = act.arg[2:0];
    act_arith  = (act_rule == RULE_ADD) || (act_rule == RULE_MUL);
    steps_done = (iter == 5'(MAX_STEPS));
    push_full  = (({1'b0, top} + (AW+1)'(1)) >= DEPTH_EXT);
    red_bad    = (act.arg == 4'd0) || (act.arg > 4'd6) ||
                 (top < AW'(rule_len(act_rule)));
    tmp_ovf    = act_arith && next_temp[8];
    rec_full   = act_arith && (nrec == 2'd2);
    red_go     = !red_bad && !tmp_ovf && !rec_full;
    rule_arith = (rule == RULE_ADD) || (rule == RULE_MUL);
    base       = top - AW'(rule_len(rule));
    base_state = (base == '0) ? 4'd0 : rd_state;
    gto        = goto_of(base_state, rule_lhs(rule));
  end

  // Next-state logic.
  always_comb begin
    fsm_next = fsm;
    unique case (fsm)
      FSM_IDLE: begin
        if (in_valid) fsm_next = FSM_DECIDE;
      end
      FSM_DECIDE: begin
        if (!out_busy) begin
          if (steps_done) fsm_next = FSM_IDLE;
          else if (act.kind == AK_REDUCE && red_go) fsm_next = FSM_REDUCE;
          else fsm_next = FSM_IDLE;
        end
      end
      FSM_REDUCE: begin
        if (!(rule_arith && out_busy)) begin
          fsm_next = gto.ok ? FSM_DECIDE : FSM_FAIL;
        end
      end
      FSM_FAIL: begin
        if (!out_busy) fsm_next = FSM_IDLE;
      end
      default: fsm_next = FSM_IDLE;
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    tok_next       = tok;
    tok_byte_next  = tok_byte;
    top_next       = top;
    top_state_next = top_state;
    top_opnd_next  = top_opnd;
    next_temp_next = next_temp;
    iter_next      = iter;
    nrec_next      = nrec;
    rule_next      = rule;
    rec_next       = rec;
    rec_valid_next = rec_valid && !out_ready;
    restart        = 1'b0;
    stk_ctl        = '0;
    wr_addr        = top + AW'(1);
    wr_state       = act.arg;
    wr_opnd        = {1'b0, tok_byte};
    rd_state_addr  = top - AW'(rule_len(act_rule));
    rd_opnd_addr   = top - ((act_rule == RULE_PAREN) ? AW'(1) : AW'(2));

    unique case (fsm)
      FSM_IDLE: begin
        if (in_valid) begin
          tok_next      = classify(in_byte);
          tok_byte_next = in_byte;
          iter_next     = '0;
          nrec_next     = '0;
        end
      end

      FSM_DECIDE: begin
        if (!out_busy) begin
          rec_next             = '0;
          rec_next.record_kind = REC_STATUS;
          rec_next.last_record = 1'b1;
          rec_next.status_code = STS_SYNTAX;
          if (steps_done) begin
            rec_valid_next = 1'b1;
            restart        = 1'b1;
          end else begin
            unique case (act.kind)
              AK_ERR: begin
                rec_valid_next = 1'b1;
                restart        = 1'b1;
              end
              AK_ACCEPT: begin
                rec_next.status_code  = STS_ACCEPTED;
                rec_next.left_is_temp = top_opnd[8];
                rec_next.left_value   = top_opnd[7:0];
                rec_valid_next        = 1'b1;
                restart               = 1'b1;
              end
              AK_SHIFT: begin
                rec_valid_next = 1'b1;
                if (push_full) begin
                  rec_next.status_code = STS_STACK;
                  restart              = 1'b1;
                end else begin
                  rec_next.status_code = STS_SHIFTED;
                  stk_ctl.wr_en        = 1'b1;
                  top_next             = top + AW'(1);
                  top_state_next       = act.arg;
                  top_opnd_next        = {1'b0, tok_byte};
                end
              end
              AK_REDUCE: begin
                iter_next = iter + 5'd1;
                if (red_bad) begin
                  rec_valid_next = 1'b1;
                  restart        = 1'b1;
                end else if (tmp_ovf) begin
                  rec_next.status_code = STS_TEMP;
                  rec_valid_next       = 1'b1;
                  restart              = 1'b1;
                end else if (rec_full) begin
                  rec_valid_next = 1'b1;
                  restart        = 1'b1;
                end else begin
                  stk_ctl.rd_en = 1'b1;
                  rule_next     = act_rule;
                end
              end
              default: ;
            endcase
          end
        end
      end

      FSM_REDUCE: begin
        if (!(rule_arith && out_busy)) begin
          // Operand of the reduced nonterminal.
          if (rule_arith) begin
            top_opnd_next          = {1'b1, next_temp[7:0]};
            rec_next               = '0;
            rec_next.record_kind   = REC_CODE;
            rec_next.dest_temp     = next_temp[7:0];
            rec_next.operator_kind = (rule == RULE_MUL) ? OP_MUL : OP_ADD;
            rec_next.left_is_temp  = rd_opnd[8];
            rec_next.left_value    = rd_opnd[7:0];
            rec_next.right_is_temp = top_opnd[8];
            rec_next.right_value   = top_opnd[7:0];
            rec_valid_next         = 1'b1;
            next_temp_next         = next_temp + 9'd1;
            nrec_next              = nrec + 2'd1;
          end else if (rule == RULE_PAREN) begin
            top_opnd_next = rd_opnd;
          end
          // Push the goto state on the shortened stack.
          wr_addr  = base + AW'(1);
          wr_state = gto.state;
          wr_opnd  = top_opnd_next;
          if (gto.ok) begin
            stk_ctl.wr_en  = 1'b1;
            top_next       = base + AW'(1);
            top_state_next = gto.state;
          end
        end
      end

      FSM_FAIL: begin
        if (!out_busy) begin
          rec_next             = '0;
          rec_next.record_kind = REC_STATUS;
          rec_next.last_record = 1'b1;
          rec_next.status_code = STS_SYNTAX;
          rec_valid_next       = 1'b1;
          restart              = 1'b1;
        end
      end

      default: ;
    endcase

    // Accept and every error start a new expression.
    if (restart) begin
      top_next       = '0;
      top_state_next = 4'd0;
      next_temp_next = 9'd1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= FSM_IDLE;
      top       <= '0;
      top_state <= 4'd0;
      next_temp <= 9'd1;
      rec_valid <= 1'b0;
      iter      <= '0;
      nrec      <= '0;
    end else begin
      fsm       <= fsm_next;
      top       <= top_next;
      top_state <= top_state_next;
      next_temp <= next_temp_next;
      rec_valid <= rec_valid_next;
      iter      <= iter_next;
      nrec      <= nrec_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    tok      <= tok_next;
    tok_byte <= tok_byte_next;
    top_opnd <= top_opnd_next;
    rule     <= rule_next;
    rec      <= rec_next;
  end

  assign in_ready  = (fsm == FSM_IDLE);
  assign out_valid = rec_valid;
  assign out_rec   = rec;

endmodule

// ===== src/slr_expression_parser_tac_top.sv =====
// SLR(1) shift-reduce parser for E->E+T|T, T->T*F|F, F->(E)|id that emits
// three-address code.
// Input: one token byte per beat on s_axis. Letters and digits are ids;
// + * ( ) $ stand for themselves and $ ends the expression.
// Output: per token, up to two three-address records (tuser low) and then
// one status record (tuser high, tlast high) on m_axis.
// Flow: a token is taken in, then each reduction it triggers runs, at most
// three per token, and then its shift, accept or error follows. Each reduction
// passes through a decide and a reduce state, as the stack memory's read port
// is registered. s_axis_tready is high only between tokens.
// A finished record waits in an output register; when the receiver stalls,
// the parser holds at its next record until that register drains.
// Reset clears the stack to the start state and the temp counter to one.
// Accept and every error do the same, so the next beat starts a new
// expression. No clearing pass is needed after reset.
module slr_expression_parser_tac_top
  import slrep_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] token_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] dest_temp, [8] operator_kind, [9] left_is_temp, [17:10] left_value,
  // [18] right_is_temp, [26:19] right_value, [29:27] status_code, [31:30] zero
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tuser,  // [0] record_kind
  output logic        m_axis_tlast   // last_record
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  stk_ctl_t      stk_ctl;
  logic [AW-1:0] wr_addr;
  logic [3:0]    wr_state;
  logic [8:0]    wr_opnd;
  logic [AW-1:0] rd_state_addr;
  logic [AW-1:0] rd_opnd_addr;
  logic [3:0]    rd_state;
  logic [8:0]    rd_opnd;
  rec_t          rec;

  // Sequencer with the action and goto tables.
  slrep_ctrl #(
    .STACK_DEPTH(STACK_DEPTH),
    .AW         (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_byte      (s_axis_tdata),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_rec      (rec),
    .stk_ctl      (stk_ctl),
    .wr_addr      (wr_addr),
    .wr_state     (wr_state),
    .wr_opnd      (wr_opnd),
    .rd_state_addr(rd_state_addr),
    .rd_opnd_addr (rd_opnd_addr),
    .rd_state     (rd_state),
    .rd_opnd      (rd_opnd)
  );

  // State and operand stacks.
  slrep_stack #(
    .STACK_DEPTH(STACK_DEPTH),
    .AW         (AW)
  ) u_stack (
    .clk          (clk),
    .ctl          (stk_ctl),
    .wr_addr      (wr_addr),
    .wr_state     (wr_state),
    .wr_opnd      (wr_opnd),
    .rd_state_addr(rd_state_addr),
    .rd_opnd_addr (rd_opnd_addr),
    .rd_state     (rd_state),
    .rd_opnd      (rd_opnd)
  );

  // Pack the record into the output beat.
  assign m_axis_tdata = {2'b00, rec.status_code, rec.right_value, rec.right_is_temp,
                         rec.left_value, rec.left_is_temp, rec.operator_kind,
                         rec.dest_temp};
  assign m_axis_tuser = rec.record_kind;
  assign m_axis_tlast = rec.last_record;

  // The status record is always the last one of a token.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == m_axis_tlast))
    else $error("status record and last flag disagree");

  // A three-address record defines a nonzero temp and carries no status.
  a_code_rec: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |->
      (m_axis_tdata[29:27] == 3'd0 && m_axis_tdata[7:0] != 8'd0))
    else $error("malformed three-address record");

  // The parser is busy in the cycle after it takes a token.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("token taken while a token is in work");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import slrep_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRESSURE_CYC = 400;
  localparam int PHASE_ITEMS  = 55;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold;
  int stall_cnt;
  int errors;
  int items_sent;

  // Shadow parser: keeps its own stacks and temp counter and queues the
  // records each accepted token byte should produce.
  class parse_scoreboard;
    localparam int DEPTH    = 32;
    localparam int TEMP_MAX = 255;

    rec_t        want_q[$];
    logic [3:0]  state_stk[DEPTH];
    logic [8:0]  opnd_stk[DEPTH];
    int unsigned top;
    int unsigned temp_no;
    act_t        action_tab[12][7];
    goto_t       goto_tab[12][3];

    function new();
      int   opnd_states[4];
      tok_t follow3[3];
      tok_t follow4[4];
      opnd_states = '{0, 4, 6, 7};
      follow3 = '{TK_PLUS, TK_RPAR, TK_END};
      follow4 = '{TK_PLUS, TK_STAR, TK_RPAR, TK_END};
      for (int s = 0; s < 12; s++) begin
        for (int t = 0; t < 7; t++) action_tab[s][t] = {AK_ERR, 4'd0};
        for (int n = 0; n < 3; n++) goto_tab[s][n] = '0;
      end
      // States waiting for an operand shift an id or an open paren.
      foreach (opnd_states[i]) begin
        action_tab[opnd_states[i]][TK_ID]   = {AK_SHIFT, 4'd5};
        action_tab[opnd_states[i]][TK_LPAR] = {AK_SHIFT, 4'd4};
      end
      action_tab[1][TK_PLUS] = {AK_SHIFT, 4'd6};
      action_tab[1][TK_END]  = {AK_ACCEPT, 4'd0};
      action_tab[2][TK_STAR] = {AK_SHIFT, 4'd7};
      action_tab[9][TK_STAR] = {AK_SHIFT, 4'd7};
      foreach (follow3[i]) begin
        action_tab[2][follow3[i]] = {AK_REDUCE, 4'(RULE_E_T)};
        action_tab[9][follow3[i]] = {AK_REDUCE, 4'(RULE_ADD)};
      end
      foreach (follow4[i]) begin
        action_tab[3][follow4[i]]  = {AK_REDUCE, 4'(RULE_T_F)};
        action_tab[5][follow4[i]]  = {AK_REDUCE, 4'(RULE_ID)};
        action_tab[10][follow4[i]] = {AK_REDUCE, 4'(RULE_MUL)};
        action_tab[11][follow4[i]] = {AK_REDUCE, 4'(RULE_PAREN)};
      end
      action_tab[8][TK_PLUS] = {AK_SHIFT, 4'd6};
      action_tab[8][TK_RPAR] = {AK_SHIFT, 4'd11};
      // Goto on E, T and F.
      goto_tab[0][NT_E] = {1'b1, 4'd1};
      goto_tab[0][NT_T] = {1'b1, 4'd2};
      goto_tab[0][NT_F] = {1'b1, 4'd3};
      goto_tab[4][NT_E] = {1'b1, 4'd8};
      goto_tab[4][NT_T] = {1'b1, 4'd2};
      goto_tab[4][NT_F] = {1'b1, 4'd3};
      goto_tab[6][NT_T] = {1'b1, 4'd9};
      goto_tab[6][NT_F] = {1'b1, 4'd3};
      goto_tab[7][NT_F] = {1'b1, 4'd10};
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < DEPTH; i++) begin
        state_stk[i] = 4'd0;
        opnd_stk[i]  = 9'd0;
      end
      top     = 0;
      temp_no = 1;
    endfunction

    function tok_t token_class(input logic [7:0] c);
      tok_t t;
      t = TK_BAD;
      if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
        t = TK_ID;
      else if (c == "+") t = TK_PLUS;
      else if (c == "*") t = TK_STAR;
      else if (c == "(") t = TK_LPAR;
      else if (c == ")") t = TK_RPAR;
      else if (c == "$") t = TK_END;
      return t;
    endfunction

    // Queue the status record that ends a token; anything but a shift restarts.
    function void close_token(input status_t sts, input logic [8:0] opnd);
      rec_t r;
      r = '0;
      r.record_kind  = REC_STATUS;
      r.left_is_temp = opnd[8];
      r.left_value   = opnd[7:0];
      r.status_code  = sts;
      r.last_record  = 1'b1;
      want_q.push_back(r);
      if (sts != STS_SHIFTED) restart();
    endfunction

    function void note_token(input logic [7:0] c);
      tok_t       tk;
      act_t       a;
      logic [3:0] st;
      logic [2:0] rule;
      int         len;
      nterm_t     lhs;
      logic [8:0] res;
      goto_t      g;
      rec_t       r;
      int         nrec;
      bit         done;
      tk   = token_class(c);
      nrec = 0;
      done = 1'b0;
      for (int step = 0; step < MAX_STEPS && !done; step++) begin
        st = state_stk[top];
        a  = (st < 12) ? action_tab[st][tk] : act_t'({AK_ERR, 4'd0});
        res = 9'd0;
        if (a.kind == AK_ERR) begin
          close_token(STS_SYNTAX, 9'd0);
          done = 1'b1;
        end else if (a.kind == AK_ACCEPT) begin
          close_token(STS_ACCEPTED, opnd_stk[top]);
          done = 1'b1;
        end else if (a.kind == AK_SHIFT) begin
          if (top + 1 >= DEPTH) begin
            close_token(STS_STACK, 9'd0);
          end else begin
            top++;
            state_stk[top] = a.arg;
            opnd_stk[top]  = {1'b0, c};
            close_token(STS_SHIFTED, 9'd0);
          end
          done = 1'b1;
        end else begin
          rule = a.arg[2:0];
          len  = (rule == RULE_ADD || rule == RULE_MUL || rule == RULE_PAREN) ? 3 : 1;
          lhs  = (rule == RULE_ADD || rule == RULE_E_T) ? NT_E :
                 (rule == RULE_MUL || rule == RULE_T_F) ? NT_T : NT_F;
          if (top < len) begin
            close_token(STS_SYNTAX, 9'd0);
            done = 1'b1;
          end else if (rule == RULE_ADD || rule == RULE_MUL) begin
            // A binary reduction defines a new temp, unless the counter ran out or the token already has two records.
            if (temp_no > TEMP_MAX) begin
              close_token(STS_TEMP, 9'd0);
              done = 1'b1;
            end else if (nrec >= 2) begin
              close_token(STS_SYNTAX, 9'd0);
              done = 1'b1;
            end else begin
              r = '0;
              r.record_kind   = REC_CODE;
              r.dest_temp     = 8'(temp_no);
              r.operator_kind = (rule == RULE_MUL) ? OP_MUL : OP_ADD;
              r.left_is_temp  = opnd_stk[top-2][8];
              r.left_value    = opnd_stk[top-2][7:0];
              r.right_is_temp = opnd_stk[top][8];
              r.right_value   = opnd_stk[top][7:0];
              r.status_code   = STS_SHIFTED;
              r.last_record   = 1'b0;
              want_q.push_back(r);
              res = {1'b1, 8'(temp_no)};
              temp_no++;
              nrec++;
            end
          end else if (rule == RULE_PAREN) begin
            res = opnd_stk[top-1];
          end else begin
            res = opnd_stk[top];
          end
          if (!done) begin
            top -= len;
            g = goto_tab[state_stk[top]][lhs];
            if (!g.ok) begin
              close_token(STS_SYNTAX, 9'd0);
              done = 1'b1;
            end else begin
              top++;
              state_stk[top] = g.state;
              opnd_stk[top]  = res;
            end
          end
        end
      end
      if (!done) close_token(STS_SYNTAX, 9'd0);
    endfunction

    // Compare one output beat with the oldest queued record.
    function int check_beat(input logic [31:0] data, input logic kind, input logic last,
                            output string why);
      rec_t w;
      int   bad;
      bad = 0;
      why = "";
      if (want_q.size() == 0) begin
        why = $sformatf("record with nothing queued: tdata=%h tuser=%b tlast=%b",
                        data, kind, last);
        return 1;
      end
      w = want_q.pop_front();
      if (kind !== w.record_kind) begin
        bad++; why = {why, $sformatf(" kind %b/%b", kind, w.record_kind)};
      end
      if (data[7:0] !== w.dest_temp) begin
        bad++; why = {why, $sformatf(" dest %h/%h", data[7:0], w.dest_temp)};
      end
      if (data[8] !== w.operator_kind) begin
        bad++; why = {why, $sformatf(" op %b/%b", data[8], w.operator_kind)};
      end
      if (data[9] !== w.left_is_temp) begin
        bad++; why = {why, $sformatf(" ltemp %b/%b", data[9], w.left_is_temp)};
      end
      if (data[17:10] !== w.left_value) begin
        bad++; why = {why, $sformatf(" left %h/%h", data[17:10], w.left_value)};
      end
      if (data[18] !== w.right_is_temp) begin
        bad++; why = {why, $sformatf(" rtemp %b/%b", data[18], w.right_is_temp)};
      end
      if (data[26:19] !== w.right_value) begin
        bad++; why = {why, $sformatf(" right %h/%h", data[26:19], w.right_value)};
      end
      if (data[29:27] !== w.status_code) begin
        bad++; why = {why, $sformatf(" status %0d/%0d", data[29:27], w.status_code)};
      end
      if (data[31:30] !== 2'b00) begin
        bad++; why = {why, $sformatf(" pad %b/00", data[31:30])};
      end
      if (last !== w.last_record) begin
        bad++; why = {why, $sformatf(" last %b/%b", last, w.last_record)};
      end
      if (bad != 0) why = {"record fields got/want:", why};
      return bad;
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  parse_scoreboard sb;

  slr_expression_parser_tac_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string why);
    errors++;
    if (errors <= 100) $display("mismatch at %0t: %s", $realtime, why);
  endtask

  // Receiver: random stalls, plus an optional long hold-off.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Output monitor and stall watchdog; sampled mid-cycle, when all is settled.
  always @(negedge clk) begin : monitor
    string why;
    int    nbad;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cnt = 0;
      else
        stall_cnt++;
      if (m_axis_tvalid && m_axis_tready) begin
        nbad = sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast, why);
        if (nbad != 0) report_mismatch(why);
      end
      if (stall_cnt >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Offer one token byte after a random gap and wait until the parser takes it.
  task automatic send_token(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    sb.note_token(b);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_token(s[i]);
  endtask

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(61);
    if (r < 10) return 8'("0" + r);
    else if (r < 36) return 8'("A" + r - 10);
    else return 8'("a" + r - 36);
  endfunction

  // A random well-formed expression ended by '$', now and then damaged.
  task automatic send_expr();
    logic [7:0] q[$];
    int    depth;
    int    operands;
    int    want_opnds;
    int    max_depth;
    int    r;
    bit    need_opnd;
    string punct_set;
    depth      = 0;
    operands   = 0;
    want_opnds = $urandom_range(1, 8);
    max_depth  = $urandom_range(0, 4);
    need_opnd  = 1'b1;
    punct_set  = "+*()$";
    forever begin
      if (need_opnd) begin
        if (depth < max_depth && operands < want_opnds && $urandom_range(3) == 0) begin
          q.push_back("(");
          depth++;
        end else begin
          q.push_back(rand_alnum());
          operands++;
          need_opnd = 1'b0;
        end
      end else if (operands >= want_opnds) begin
        if (depth == 0) break;
        q.push_back(")");
        depth--;
      end else begin
        r = $urandom_range(2);
        if (r == 0 && depth > 0) begin
          q.push_back(")");
          depth--;
        end else begin
          q.push_back((r == 1) ? 8'("+") : 8'("*"));
          need_opnd = 1'b1;
        end
      end
    end
    q.push_back("$");
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(2))
        0:       q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
        1:       q.delete($urandom_range(q.size() - 1));
        default: q.insert($urandom_range(q.size()), punct_set[$urandom_range(4)]);
      endcase
    end
    foreach (q[i]) send_token(q[i]);
  endtask

  initial begin : main
    int phase_end;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    rst           = 1'b1;
    rx_hold       = 0;
    stall_cnt     = 0;
    errors        = 0;
    items_sent    = 0;
    tx_idle_pct   = 30;
    rx_idle_pct   = 73;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: accepts, both operators, parens, alphanumeric extremes,
    // unknown bytes, error with no action, and records ahead of an error.
    send_text("a$");
    send_text("(z)*9+A*Z$");
    send_text("0+b*c)");
    send_text(")");
    send_token(8'h00);
    send_token(8'hFF);
    send_text("q+$");

    // Nesting one level too deep overflows the stack.
    repeat (32) send_token("(");
    send_text("a$");

    // A chain of products back to back, with no idling.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_token("x");
    repeat (8) begin
      send_token("*");
      send_token(rand_alnum());
    end
    send_token("$");
    send_text("b$");

    // Random expressions under each idling pattern.
    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 30 : (mode == 1) ? 73 : 0;
      rx_idle_pct = (mode == 0) ? 73 : (mode == 1) ? 30 : 0;
      if (mode == 2) rx_hold = PRESSURE_CYC;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(99) < 10) send_token(8'($urandom_range(255)));
        else send_expr();
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/slrep_pkg.sv
src/slrep_stack.sv
src/slrep_ctrl.sv
src/slr_expression_parser_tac_top.sv
bench/tb.sv
